// ===== hw/rtl/ucsd_pkg.sv =====
// Shared types and constants for the UTF-8 / CESU-8 stream decoder.
// Used by ucsd_rsp_fifo and utf8_cesu_stream_decoder; no dependencies.
`default_nettype none

package ucsd_pkg;

   localparam logic [7:0]  LeadTwo    = 8'hC0;
   localparam logic [7:0]  LeadThree  = 8'hE0;
   localparam logic [7:0]  LeadFour   = 8'hF0;
   localparam logic [7:0]  LeadFive   = 8'hF8;
   localparam logic [7:0]  LeadSix    = 8'hFC;
   localparam logic [7:0]  RawHigh    = 8'hFE;
   localparam logic [7:0]  PairLead   = 8'hED;
   localparam logic [30:0] SurBase    = 31'h0000_D800;
   localparam logic [30:0] SurLowBase = 31'h0000_DC00;
   localparam logic [10:0] PlaneAdd   = 11'h040;

   localparam logic [1:0] PhaseLead = 2'd0;
   localparam logic [1:0] PhaseMid  = 2'd1;
   localparam logic [1:0] PhaseLast = 2'd2;

   localparam int RspDepth = 4;
   localparam int RspPtrW  = $clog2(RspDepth);
   localparam int RspCntW  = $clog2(RspDepth + 1);

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [30:0] code_point;
      logic        run_last;
   } rsp_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    item0;
      rsp_type    item1;
   } push_type;

   typedef struct packed {
      logic       emit;
      logic       load;
      logic [2:0] more;
      logic [4:0] accum;
   } fresh_type;

endpackage

`default_nettype wire

// ===== hw/rtl/ucsd_rsp_fifo.sv =====
// Result queue: takes up to two result transactions per cycle, delivers one while rsp_stall is low.
// Depends on ucsd_pkg for the result and push types and the depth.
`default_nettype none

module ucsd_rsp_fifo (
   input  wire               clock,
   input  wire               reset,
   input  ucsd_pkg::push_type push,
   output logic              space_ok,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output ucsd_pkg::rsp_type rsp_data
);
   import ucsd_pkg::*;

   rsp_type mem [RspDepth];

   logic [RspPtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RspPtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RspCntW-1:0] cnt_ff, cnt_in;
   logic [RspPtrW-1:0] wr_next;
   logic               pop;

   assign wr_next   = wr_ptr_ff + RspPtrW'(1);
   assign rsp_valid = (cnt_ff != '0);
   assign rsp_data  = mem[rd_ptr_ff];
   assign space_ok  = (cnt_ff <= RspCntW'(RspDepth - 2));
   assign pop       = rsp_valid && !rsp_stall;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + RspPtrW'(push.count);
      rd_ptr_in = pop ? rd_ptr_ff + RspPtrW'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + RspCntW'(push.count) - RspCntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem[wr_ptr_ff] <= push.item0;
      end
      if (push.count == 2'd2) begin
         mem[wr_next] <= push.item1;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= RspCntW'(RspDepth))
      else $error("result queue count out of range");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> space_ok)
      else $error("push into result queue without room");

endmodule

`default_nettype wire

// ===== hw/rtl/utf8_cesu_stream_decoder.sv =====
// Top level of the UTF-8 stream decoder with CESU-8 surrogate pair merging.
// Depends on ucsd_pkg and ucsd_rsp_fifo.
//
// Usage:
//   req_ channel carries one text byte per transaction, with end_of_text set
//   on the final byte of a text. rsp_ channel carries one code point per
//   transaction; run_last marks the last result caused by a given byte.
//   Each byte gives zero, one or two results.
//   A result is registered in the result queue before it is offered on rsp_.
//   Throughput: one byte per cycle while each byte gives at most one result
//   and the receiver keeps up; the decode step is one level of logic between
//   the sequence state registers and a four-entry result queue. A byte that
//   gives two results is delivered as two transactions at the rsp_ port.
//   req_stall rises when the queue has room for fewer than two results, so
//   a stalled receiver backs the stream up after three or four results.
//   Reset (synchronous) clears the sequence state and empties the queue;
//   end_of_text returns all decode state to its reset values.
`default_nettype none

module utf8_cesu_stream_decoder (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  ucsd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output ucsd_pkg::rsp_type rsp_data
);
   import ucsd_pkg::*;

   logic [7:0]  lead_ff, lead_in;
   logic [30:0] accum_ff, accum_in;
   logic [2:0]  left_ff, left_in;
   logic        sur_wait_ff, sur_wait_in;
   logic [9:0]  sur_bits_ff, sur_bits_in;
   logic [1:0]  phase_ff, phase_in;
   logic [7:0]  mid_ff, mid_in;

   logic        accept;
   logic        space_ok;
   logic [7:0]  b;
   logic        eot;
   logic [1:0]  n;
   logic [30:0] cp0, cp1;
   logic [30:0] sur;
   logic [30:0] merged;
   logic [30:0] acc_next;
   logic [2:0]  left_dec;
   fresh_type   fr;
   push_type    push;

   function automatic fresh_type fresh_decode(input logic [7:0] x, input logic last);
      fresh_type f;
      f = '0;
      if (x < LeadTwo || x >= RawHigh) begin
         f.emit = 1'b1;
      end else if (last) begin
         f.emit = 1'b1;
      end else begin
         f.load = 1'b1;
         priority if (x < LeadThree) begin
            f.more  = 3'd1;
            f.accum = x[4:0];
         end else if (x < LeadFour) begin
            f.more  = 3'd2;
            f.accum = {1'b0, x[3:0]};
         end else if (x < LeadFive) begin
            f.more  = 3'd3;
            f.accum = {2'b0, x[2:0]};
         end else if (x < LeadSix) begin
            f.more  = 3'd4;
            f.accum = {3'b0, x[1:0]};
         end else begin
            f.more  = 3'd5;
            f.accum = {4'b0, x[0]};
         end
      end
      return f;
   endfunction

   assign accept    = req_valid && !req_stall;
   assign req_stall = !space_ok;
   assign b         = req_data.in_byte;
   assign eot       = req_data.end_of_text;
   assign fr        = fresh_decode(b, eot);
   assign sur       = SurBase | {21'b0, sur_bits_ff};
   assign merged    = {10'b0, 11'(sur_bits_ff) + PlaneAdd, mid_ff[3:0], b[5:0]};
   assign acc_next  = {accum_ff[24:0], b[5:0]};
   assign left_dec  = left_ff - 3'd1;

   always_comb begin
      lead_in     = lead_ff;
      accum_in    = accum_ff;
      left_in     = left_ff;
      sur_wait_in = sur_wait_ff;
      sur_bits_in = sur_bits_ff;
      phase_in    = phase_ff;
      mid_in      = mid_ff;
      n           = 2'd0;
      cp0         = '0;
      cp1         = '0;
      if (accept) begin
         if (sur_wait_ff) begin
            if (phase_ff == PhaseLead) begin
               if (b == PairLead) begin
                  if (eot) begin
                     n   = 2'd2;
                     cp0 = sur;
                     cp1 = {23'b0, PairLead};
                  end else begin
                     phase_in = PhaseMid;
                  end
               end else begin
                  n           = 2'd1;
                  cp0         = sur;
                  sur_wait_in = 1'b0;
                  sur_bits_in = '0;
                  phase_in    = PhaseLead;
                  mid_in      = '0;
                  if (fr.emit) begin
                     n   = 2'd2;
                     cp1 = {23'b0, b};
                  end
                  if (fr.load) begin
                     lead_in  = b;
                     accum_in = {26'b0, fr.accum};
                     left_in  = fr.more;
                  end
               end
            end else if (phase_ff == PhaseMid) begin
               if (eot) begin
                  n   = 2'd2;
                  cp0 = sur;
                  cp1 = {23'b0, PairLead};
               end else begin
                  mid_in   = b;
                  phase_in = PhaseLast;
               end
            end else begin
               n           = 2'd1;
               cp0         = merged;
               sur_wait_in = 1'b0;
               sur_bits_in = '0;
               phase_in    = PhaseLead;
               mid_in      = '0;
            end
         end else if (left_ff != 3'd0) begin
            accum_in = acc_next;
            left_in  = left_dec;
            if (left_dec != 3'd0) begin
               if (eot) begin
                  n        = 2'd1;
                  cp0      = {23'b0, lead_ff};
                  lead_in  = '0;
                  accum_in = '0;
                  left_in  = '0;
               end
            end else begin
               if (!eot && lead_ff >= LeadThree && lead_ff < LeadFour &&
                   acc_next >= SurBase && acc_next < SurLowBase) begin
                  sur_wait_in = 1'b1;
                  sur_bits_in = acc_next[9:0];
                  phase_in    = PhaseLead;
                  mid_in      = '0;
               end else begin
                  n   = 2'd1;
                  cp0 = acc_next;
               end
               lead_in  = '0;
               accum_in = '0;
               left_in  = '0;
            end
         end else begin
            if (fr.emit) begin
               n   = 2'd1;
               cp0 = {23'b0, b};
            end
            if (fr.load) begin
               lead_in  = b;
               accum_in = {26'b0, fr.accum};
               left_in  = fr.more;
            end
         end
         if (eot) begin
            lead_in     = '0;
            accum_in    = '0;
            left_in     = '0;
            sur_wait_in = 1'b0;
            sur_bits_in = '0;
            phase_in    = PhaseLead;
            mid_in      = '0;
         end
      end
   end

   always_comb begin
      push.count            = n;
      push.item0.code_point = cp0;
      push.item0.run_last   = (n == 2'd1);
      push.item1.code_point = cp1;
      push.item1.run_last   = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_ff     <= '0;
         accum_ff    <= '0;
         left_ff     <= '0;
         sur_wait_ff <= 1'b0;
         sur_bits_ff <= '0;
         phase_ff    <= PhaseLead;
         mid_ff      <= '0;
      end else begin
         lead_ff     <= lead_in;
         accum_ff    <= accum_in;
         left_ff     <= left_in;
         sur_wait_ff <= sur_wait_in;
         sur_bits_ff <= sur_bits_in;
         phase_ff    <= phase_in;
         mid_ff      <= mid_in;
      end
   end

   ucsd_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space_ok  (space_ok),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && eot) |=> (left_ff == 3'd0 && !sur_wait_ff && phase_ff == PhaseLead))
      else $error("decode state not cleared after end of text");

   a_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(sur_wait_ff && left_ff != 3'd0))
      else $error("surrogate held while a sequence is open");

   a_run_last: assert property (@(posedge clock) disable iff (reset)
      (push.count == 2'd2) |-> (!push.item0.run_last && push.item1.run_last))
      else $error("run_last misplaced on a two-result transaction");

endmodule

`default_nettype wire
